// ----- sv/dmfd_pkg.sv -----
// ----------------------------------------------------------------------------
// dmfd_pkg
// types, register indexes and cordic constants of the multi-frame despreader
// ----------------------------------------------------------------------------
package dmfd_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_SPAN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_SYMBOLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATE_EACH_SYMBOL = 2'd2;

    localparam logic [8:0] SPAN_RESET = 9'd16;
    localparam logic [6:0] PAYLOAD_RESET = 7'd16;

    localparam int CORDIC_STEPS = 14;
    localparam int CW = 51;
    localparam logic signed [16:0] INV_GAIN = 17'sd39797;

    typedef logic signed [CW-1:0] t_cval;

    function automatic logic signed [16:0] arc_step(input logic [3:0] i);
        logic signed [16:0] v;
        case (i)
            4'd0:    v = 17'sd8192;
            4'd1:    v = 17'sd4836;
            4'd2:    v = 17'sd2555;
            4'd3:    v = 17'sd1297;
            4'd4:    v = 17'sd651;
            4'd5:    v = 17'sd326;
            4'd6:    v = 17'sd163;
            4'd7:    v = 17'sd81;
            4'd8:    v = 17'sd41;
            4'd9:    v = 17'sd20;
            4'd10:   v = 17'sd10;
            4'd11:   v = 17'sd5;
            4'd12:   v = 17'sd3;
            4'd13:   v = 17'sd1;
            default: v = 17'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
        logic signed [31:0] r;
        if (x > 40'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (x < -40'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

// ----- sv/dmfd_ram.sv -----
// ----------------------------------------------------------------------------
// dmfd_ram
// generic one-write one-read synchronous ram with registered read
// ----------------------------------------------------------------------------
module dmfd_ram #(
    parameter int W = 32,
    parameter int D = 16,
    parameter int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/dsss_multi_frame_despreader_core.sv -----
// ----------------------------------------------------------------------------
// dsss_multi_frame_despreader_core
// despreads up to MAX_FRAMES overlapping frames against a coefficient table
// ----------------------------------------------------------------------------
// A sample word visits every frame slot in turn through one complex multiply-
// accumulate fed from the coefficient ram. A slot that closes a symbol goes on,
// with rotation, through 14 cordic steps and a gain scaling before the symbol
// is written. When the oldest frame is complete its symbols are read from the
// symbol ram and handed out one word at a time, each held while the output is
// stalled. The rams hold unknown data until written; no clearing pass is run.
module dsss_multi_frame_despreader_core #(
    parameter int MAX_FRAMES = 4,
    parameter int MAX_PAYLOAD = 64,
    parameter int MAX_SPAN = 256,
    parameter int CODE_SETS = 4,
    parameter int SET_DEPTH = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dmfd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dmfd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_func,
    input  logic signed [15:0]                i_sample_re,
    input  logic signed [15:0]                i_sample_im,
    input  logic                              i_frame_start,
    input  logic [15:0]                       i_start_phase,
    input  logic signed [15:0]                i_phase_step,
    input  logic [1:0]                        i_code_set,
    input  logic [11:0]                       i_coef_index,
    input  logic signed [15:0]                i_coef_re,
    input  logic signed [15:0]                i_coef_im,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [31:0]                o_symbol_re,
    output logic signed [31:0]                o_symbol_im,
    output logic                              o_last_of_frame
);

    localparam int SW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int SCW = $clog2(MAX_SPAN + 1);
    localparam int PCW = $clog2(MAX_PAYLOAD + 1);
    localparam int IW = PCW + SCW;
    localparam int TD = CODE_SETS * SET_DEPTH;
    localparam int TAW = (TD > 1) ? $clog2(TD) : 1;
    localparam int SD = MAX_FRAMES * MAX_PAYLOAD;
    localparam int SAW = (SD > 1) ? $clog2(SD) : 1;
    localparam int CW = dmfd_pkg::CW;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_MUL, S_ACC, S_PRE, S_ROT, S_SC, S_WR, S_NEXT, S_CHK,
        S_ERD, S_EDAT, S_EOUT
    } t_state;

    t_state r_state;

    logic [8:0] r_span;
    logic [6:0] r_pay;
    logic       r_rot;

    logic              r_active [MAX_FRAMES];
    logic [PCW-1:0]    r_sym    [MAX_FRAMES];
    logic [SCW-1:0]    r_samp   [MAX_FRAMES];
    logic [15:0]       r_phase  [MAX_FRAMES];
    logic [15:0]       r_step   [MAX_FRAMES];
    logic [1:0]        r_set    [MAX_FRAMES];
    logic signed [47:0] r_acc_re [MAX_FRAMES];
    logic signed [47:0] r_acc_im [MAX_FRAMES];

    logic [SW-1:0]  r_head, r_tail, r_slot;
    logic [PCW-1:0] r_k;
    logic [3:0]     r_i;
    logic [1:0]     r_sc;

    logic signed [15:0] r_sr, r_si;
    logic               r_cvalid;
    logic signed [31:0] r_prr, r_pii, r_pri, r_pir;
    dmfd_pkg::t_cval    r_x, r_y;
    logic signed [16:0] r_t;
    logic signed [43:0] r_lo;
    logic signed [31:0] r_res_re, r_res_im;

    logic [SCW-1:0] span_c;
    logic [PCW-1:0] pay_c;
    logic [IW-1:0]  cidx;
    logic           cidx_ok;
    logic [TAW-1:0] coef_raddr;
    logic [31:0]    coef_rdata;
    logic           coef_we;
    logic [TAW-1:0] coef_waddr;
    logic [SAW-1:0] store_addr_w, store_addr_r;
    logic [63:0]    store_rdata;
    logic           store_we;
    logic signed [15:0] cr, ci;
    logic signed [47:0] n_acc_re, n_acc_im;
    logic [SCW-1:0] n_samp;
    dmfd_pkg::t_cval x_sh, y_sh;
    logic signed [26:0] sc_op;
    logic signed [43:0] sc_prod;
    logic signed [69:0] sc_sum;
    logic [SW-1:0]  n_slot_inc, n_head_inc, n_tail_inc;

    always_comb begin
        if (r_span == 9'd0) begin
            span_c = SCW'(1);
        end else if (32'(r_span) > MAX_SPAN) begin
            span_c = SCW'(MAX_SPAN);
        end else begin
            span_c = SCW'(r_span);
        end
        if (r_pay == 7'd0) begin
            pay_c = PCW'(1);
        end else if (32'(r_pay) > MAX_PAYLOAD) begin
            pay_c = PCW'(MAX_PAYLOAD);
        end else begin
            pay_c = PCW'(r_pay);
        end
    end

    always_comb begin
        if (r_rot) begin
            cidx = IW'(r_samp[r_slot]);
        end else begin
            cidx = IW'(r_sym[r_slot] * span_c) + IW'(r_samp[r_slot]);
        end
        cidx_ok = (32'(r_set[r_slot]) < CODE_SETS) && (32'(cidx) < SET_DEPTH);
        coef_raddr = TAW'(32'(r_set[r_slot]) * SET_DEPTH + 32'(cidx));
        coef_we = (r_state == S_IDLE) && i_valid && i_func
                  && (32'(i_code_set) < CODE_SETS) && (32'(i_coef_index) < SET_DEPTH);
        coef_waddr = TAW'(32'(i_code_set) * SET_DEPTH + 32'(i_coef_index));
    end

    dmfd_ram #(.W(32), .D(TD), .AW(TAW)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (coef_waddr),
        .i_wdata ({i_coef_re, i_coef_im}),
        .i_raddr (coef_raddr),
        .o_rdata (coef_rdata)
    );

    assign store_we = (r_state == S_WR);
    assign store_addr_w = SAW'(32'(r_slot) * MAX_PAYLOAD + 32'(r_sym[r_slot]));
    assign store_addr_r = SAW'(32'(r_slot) * MAX_PAYLOAD + 32'(r_k));

    dmfd_ram #(.W(64), .D(SD), .AW(SAW)) u_store_ram (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (store_addr_w),
        .i_wdata ({r_res_re, r_res_im}),
        .i_raddr (store_addr_r),
        .o_rdata (store_rdata)
    );

    always_comb begin
        cr = r_cvalid ? coef_rdata[31:16] : 16'sd0;
        ci = r_cvalid ? coef_rdata[15:0] : 16'sd0;
        n_acc_re = r_acc_re[r_slot] + 48'(r_prr) - 48'(r_pii);
        n_acc_im = r_acc_im[r_slot] + 48'(r_pri) + 48'(r_pir);
        n_samp = r_samp[r_slot] + SCW'(1);
        x_sh = r_x >>> r_i;
        y_sh = r_y >>> r_i;
        case (r_sc)
            2'd0:    sc_op = {1'b0, r_x[25:0]};
            2'd1:    sc_op = 27'($signed(r_x[CW-1:26]));
            2'd2:    sc_op = {1'b0, r_y[25:0]};
            default: sc_op = 27'($signed(r_y[CW-1:26]));
        endcase
        sc_prod = 44'(sc_op * dmfd_pkg::INV_GAIN);
        sc_sum = 70'(r_lo) + (70'(sc_prod) <<< 26);
        n_slot_inc = (32'(r_slot) == MAX_FRAMES - 1) ? '0 : r_slot + SW'(1);
        n_head_inc = (32'(r_head) == MAX_FRAMES - 1) ? '0 : r_head + SW'(1);
        n_tail_inc = (32'(r_tail) == MAX_FRAMES - 1) ? '0 : r_tail + SW'(1);
    end

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_span <= dmfd_pkg::SPAN_RESET;
            r_pay <= dmfd_pkg::PAYLOAD_RESET;
            r_rot <= 1'b1;
            r_head <= '0;
            r_tail <= '0;
            r_slot <= '0;
            o_valid <= 1'b0;
            for (int s = 0; s < MAX_FRAMES; s++) begin
                r_active[s] <= 1'b0;
                r_sym[s] <= '0;
                r_samp[s] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    dmfd_pkg::REG_SYMBOL_SPAN:        r_span <= i_cfg_data;
                    dmfd_pkg::REG_PAYLOAD_SYMBOLS:    r_pay <= i_cfg_data[6:0];
                    dmfd_pkg::REG_ROTATE_EACH_SYMBOL: r_rot <= i_cfg_data[0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_func) begin
                            r_slot <= r_head;
                            r_state <= S_CHK;
                        end else begin
                            r_sr <= i_sample_re;
                            r_si <= i_sample_im;
                            if (i_frame_start && !r_active[r_tail]) begin
                                r_active[r_tail] <= 1'b1;
                                r_sym[r_tail] <= '0;
                                r_samp[r_tail] <= '0;
                                r_phase[r_tail] <= i_start_phase;
                                r_step[r_tail] <= i_phase_step;
                                r_set[r_tail] <= i_code_set;
                                r_acc_re[r_tail] <= '0;
                                r_acc_im[r_tail] <= '0;
                                r_tail <= n_tail_inc;
                            end
                            r_slot <= '0;
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_cvalid <= cidx_ok;
                    if (r_active[r_slot] && r_sym[r_slot] < pay_c) begin
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_MUL: begin
                    r_prr <= r_sr * cr;
                    r_pii <= r_si * ci;
                    r_pri <= r_sr * ci;
                    r_pir <= r_si * cr;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (n_samp >= span_c) begin
                        r_samp[r_slot] <= '0;
                        r_acc_re[r_slot] <= '0;
                        r_acc_im[r_slot] <= '0;
                        r_x <= CW'(n_acc_re);
                        r_y <= CW'(n_acc_im);
                        if (r_rot) begin
                            r_state <= S_PRE;
                        end else begin
                            r_res_re <= dmfd_pkg::sat32(40'(n_acc_re >>> 15));
                            r_res_im <= dmfd_pkg::sat32(40'(n_acc_im >>> 15));
                            r_state <= S_WR;
                        end
                    end else begin
                        r_samp[r_slot] <= n_samp;
                        r_acc_re[r_slot] <= n_acc_re;
                        r_acc_im[r_slot] <= n_acc_im;
                        r_state <= S_NEXT;
                    end
                end
                S_PRE: begin
                    if ($signed(16'(16'd0 - r_phase[r_slot])) > 16'sd16384) begin
                        r_x <= -r_x;
                        r_y <= -r_y;
                        r_t <= 17'($signed(16'(16'd0 - r_phase[r_slot]))) - 17'sd32768;
                    end else if ($signed(16'(16'd0 - r_phase[r_slot])) < -16'sd16384) begin
                        r_x <= -r_x;
                        r_y <= -r_y;
                        r_t <= 17'($signed(16'(16'd0 - r_phase[r_slot]))) + 17'sd32768;
                    end else begin
                        r_t <= 17'($signed(16'(16'd0 - r_phase[r_slot])));
                    end
                    r_i <= '0;
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    if (r_t >= 0) begin
                        r_x <= r_x - y_sh;
                        r_y <= r_y + x_sh;
                        r_t <= r_t - dmfd_pkg::arc_step(r_i);
                    end else begin
                        r_x <= r_x + y_sh;
                        r_y <= r_y - x_sh;
                        r_t <= r_t + dmfd_pkg::arc_step(r_i);
                    end
                    r_i <= r_i + 4'd1;
                    if (32'(r_i) == dmfd_pkg::CORDIC_STEPS - 1) begin
                        r_sc <= 2'd0;
                        r_state <= S_SC;
                    end
                end
                S_SC: begin
                    r_sc <= r_sc + 2'd1;
                    case (r_sc)
                        2'd0, 2'd2: r_lo <= sc_prod;
                        2'd1:       r_res_re <= dmfd_pkg::sat32(40'(sc_sum >>> 31));
                        default: begin
                            r_res_im <= dmfd_pkg::sat32(40'(sc_sum >>> 31));
                            r_state <= S_WR;
                        end
                    endcase
                end
                S_WR: begin
                    r_sym[r_slot] <= r_sym[r_slot] + PCW'(1);
                    if (r_rot) begin
                        r_phase[r_slot] <= r_phase[r_slot] + 16'(r_step[r_slot] * span_c);
                    end
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    if (32'(r_slot) == MAX_FRAMES - 1) begin
                        r_slot <= r_head;
                        r_state <= S_CHK;
                    end else begin
                        r_slot <= n_slot_inc;
                        r_state <= S_RD;
                    end
                end
                S_CHK: begin
                    r_k <= '0;
                    if (r_active[r_slot] && r_sym[r_slot] >= pay_c) begin
                        r_state <= S_ERD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_ERD: begin
                    r_state <= S_EDAT;
                end
                S_EDAT: begin
                    o_symbol_re <= store_rdata[63:32];
                    o_symbol_im <= store_rdata[31:0];
                    o_last_of_frame <= (r_k == pay_c - PCW'(1));
                    o_valid <= 1'b1;
                    r_state <= S_EOUT;
                end
                S_EOUT: begin
                    if (!i_stall) begin
                        o_valid <= 1'b0;
                        if (o_last_of_frame) begin
                            r_active[r_slot] <= 1'b0;
                            r_sym[r_slot] <= '0;
                            r_samp[r_slot] <= '0;
                            r_head <= n_head_inc;
                            r_state <= S_IDLE;
                        end else begin
                            r_k <= r_k + PCW'(1);
                            r_state <= S_ERD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_idle_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_valid)
        else $error("output word pending while input side idle");

    a_last_frees_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_of_frame && !i_stall) |=> (r_head != $past(r_head)
            || MAX_FRAMES == 1) && r_state == S_IDLE)
        else $error("head slot not released after last word");

endmodule

// ----- verif/dmfd_despread_checker.sv -----
// ----------------------------------------------------------------------------
// dmfd_despread_checker
// watches the sample, symbol and register ports of the despreader, predicts
// every emitted symbol word from its own copy of the slot state and compares
// ----------------------------------------------------------------------------
module dmfd_despread_checker #(
    parameter int MAX_FRAMES = 4,
    parameter int MAX_PAYLOAD = 64,
    parameter int MAX_SPAN = 256,
    parameter int CODE_SETS = 4,
    parameter int SET_DEPTH = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dmfd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dmfd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_valid,
    input  logic                              i_stall_in,
    input  logic                              i_func,
    input  logic signed [15:0]                i_sample_re,
    input  logic signed [15:0]                i_sample_im,
    input  logic                              i_frame_start,
    input  logic [15:0]                       i_start_phase,
    input  logic signed [15:0]                i_phase_step,
    input  logic [1:0]                        i_code_set,
    input  logic [11:0]                       i_coef_index,
    input  logic signed [15:0]                i_coef_re,
    input  logic signed [15:0]                i_coef_im,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic signed [31:0]                i_symbol_re,
    input  logic signed [31:0]                i_symbol_im,
    input  logic                              i_last_of_frame,
    output int                                o_errors,
    output int                                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               last;
    } t_sym_word;

    t_sym_word          symbols_due_q[$];
    logic signed [15:0] tap_re[CODE_SETS*SET_DEPTH];
    logic signed [15:0] tap_im[CODE_SETS*SET_DEPTH];
    bit                 busy[MAX_FRAMES];
    int unsigned        n_sym[MAX_FRAMES];
    int unsigned        n_smp[MAX_FRAMES];
    int unsigned        phase[MAX_FRAMES];
    int unsigned        step[MAX_FRAMES];
    int unsigned        cset[MAX_FRAMES];
    longint             acc_re[MAX_FRAMES];
    longint             acc_im[MAX_FRAMES];
    logic signed [31:0] held_re[MAX_FRAMES*MAX_PAYLOAD];
    logic signed [31:0] held_im[MAX_FRAMES*MAX_PAYLOAD];
    int unsigned        head;
    int unsigned        tail;
    int unsigned        span_reg;
    int unsigned        pay_reg;
    bit                 rot_reg;

    function automatic logic signed [31:0] clip32(input longint x);
        if (x > 64'sd2147483647) return 32'sh7fffffff;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic void derotate(inout longint x, inout longint y, input int unsigned ph);
        int     arc[14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};
        int     t;
        longint nx;
        t = (65536 - (ph & 32'hffff)) & 32'hffff;
        if (t >= 32768) t -= 65536;
        if (t > 16384) begin
            x = -x; y = -y; t -= 32768;
        end else if (t < -16384) begin
            x = -x; y = -y; t += 32768;
        end
        for (int i = 0; i < 14; i++) begin
            if (t >= 0) begin
                nx = x - (y >>> i); y = y + (x >>> i); t -= arc[i];
            end else begin
                nx = x + (y >>> i); y = y - (x >>> i); t += arc[i];
            end
            x = nx;
        end
    endfunction

    task automatic despread_word();
        int unsigned span, pay, idx, pos;
        longint      sr, si, cr, ci, vr, vi;
        t_sym_word   nw;
        span = (span_reg < 1) ? 1 : (span_reg > MAX_SPAN) ? MAX_SPAN : span_reg;
        pay = (pay_reg < 1) ? 1 : (pay_reg > MAX_PAYLOAD) ? MAX_PAYLOAD : pay_reg;
        if (i_func) begin
            if (i_code_set < CODE_SETS && i_coef_index < SET_DEPTH) begin
                tap_re[i_code_set*SET_DEPTH + i_coef_index] = i_coef_re;
                tap_im[i_code_set*SET_DEPTH + i_coef_index] = i_coef_im;
            end
        end else begin
            sr = i_sample_re;
            si = i_sample_im;
            if (i_frame_start && !busy[tail]) begin
                busy[tail] = 1;
                n_sym[tail] = 0;
                n_smp[tail] = 0;
                phase[tail] = i_start_phase;
                step[tail] = {16'd0, i_phase_step};
                cset[tail] = i_code_set;
                acc_re[tail] = 0;
                acc_im[tail] = 0;
                tail = (tail + 1) % MAX_FRAMES;
            end
            for (int s = 0; s < MAX_FRAMES; s++) begin
                if (busy[s] && n_sym[s] < pay) begin
                    idx = rot_reg ? n_smp[s] : n_sym[s] * span + n_smp[s];
                    cr = 0;
                    ci = 0;
                    if (cset[s] < CODE_SETS && idx < SET_DEPTH) begin
                        cr = tap_re[cset[s]*SET_DEPTH + idx];
                        ci = tap_im[cset[s]*SET_DEPTH + idx];
                    end
                    acc_re[s] += sr * cr - si * ci;
                    acc_im[s] += sr * ci + si * cr;
                    n_smp[s]++;
                    if (n_smp[s] >= span) begin
                        vr = acc_re[s];
                        vi = acc_im[s];
                        pos = s * MAX_PAYLOAD + n_sym[s];
                        if (rot_reg) begin
                            derotate(vr, vi, phase[s]);
                            vr = (vr * 39797) >>> 31;
                            vi = (vi * 39797) >>> 31;
                            phase[s] = (phase[s] + step[s] * span) & 32'hffff;
                        end else begin
                            vr = vr >>> 15;
                            vi = vi >>> 15;
                        end
                        held_re[pos] = clip32(vr);
                        held_im[pos] = clip32(vi);
                        n_sym[s]++;
                        n_smp[s] = 0;
                        acc_re[s] = 0;
                        acc_im[s] = 0;
                    end
                end
            end
        end
        if (busy[head] && n_sym[head] >= pay) begin
            for (int k = 0; k < pay; k++) begin
                nw.re = held_re[head*MAX_PAYLOAD + k];
                nw.im = held_im[head*MAX_PAYLOAD + k];
                nw.last = (k + 1 == pay);
                symbols_due_q.insert(symbols_due_q.size(), nw);
            end
            busy[head] = 0;
            n_sym[head] = 0;
            n_smp[head] = 0;
            head = (head + 1) % MAX_FRAMES;
        end
    endtask

    always @(posedge i_clk) begin
        t_sym_word w;
        if (!i_rst_n) begin
            for (int s = 0; s < MAX_FRAMES; s++) begin
                busy[s] = 0; n_sym[s] = 0; n_smp[s] = 0; phase[s] = 0;
                step[s] = 0; cset[s] = 0; acc_re[s] = 0; acc_im[s] = 0;
            end
            head = 0;
            tail = 0;
            span_reg = dmfd_pkg::SPAN_RESET;
            pay_reg = dmfd_pkg::PAYLOAD_RESET;
            rot_reg = 1;
            symbols_due_q.delete();
            o_errors = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (symbols_due_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("unexpected symbol word re=%0d im=%0d last=%0b",
                                 i_symbol_re, i_symbol_im, i_last_of_frame);
                end else begin
                    w = symbols_due_q.pop_front();
                    if (w.re !== i_symbol_re || w.im !== i_symbol_im ||
                        w.last !== i_last_of_frame) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("symbol mismatch: exp %0d %0d %0b got %0d %0d %0b",
                                     w.re, w.im, w.last, i_symbol_re, i_symbol_im,
                                     i_last_of_frame);
                    end
                end
            end
            if (i_valid && !i_stall_in) despread_word();
            if (i_cfg_we) begin
                case (i_cfg_index)
                    dmfd_pkg::REG_SYMBOL_SPAN:        span_reg = i_cfg_data;
                    dmfd_pkg::REG_PAYLOAD_SYMBOLS:    pay_reg = i_cfg_data[6:0];
                    dmfd_pkg::REG_ROTATE_EACH_SYMBOL: rot_reg = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        o_pending = symbols_due_q.size();
    end

endmodule

// ----- verif/tb_dsss_multi_frame_despreader_core.sv -----
// ----------------------------------------------------------------------------
// tb_dsss_multi_frame_despreader_core
// drives coefficient loads, directed frame cases and random frame streams
// under several register settings, with random gaps and output stalls
// ----------------------------------------------------------------------------
module tb_dsss_multi_frame_despreader_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [dmfd_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [dmfd_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                            i_valid;
    logic                            o_stall;
    logic                            i_func;
    logic signed [15:0]              i_sample_re;
    logic signed [15:0]              i_sample_im;
    logic                            i_frame_start;
    logic [15:0]                     i_start_phase;
    logic signed [15:0]              i_phase_step;
    logic [1:0]                      i_code_set;
    logic [11:0]                     i_coef_index;
    logic signed [15:0]              i_coef_re;
    logic signed [15:0]              i_coef_im;
    logic                            o_valid;
    logic                            i_stall;
    logic signed [31:0]              o_symbol_re;
    logic signed [31:0]              o_symbol_im;
    logic                            o_last_of_frame;
    int                              n_errors;
    int                              n_pending;
    int                              idle_cycles;
    int                              n_words;
    bit                              calm;
    bit                              hold_req;

    dsss_multi_frame_despreader_core u_top (.*);

    dmfd_despread_checker u_chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data, .i_valid,
        .i_stall_in(o_stall), .i_func, .i_sample_re, .i_sample_im, .i_frame_start,
        .i_start_phase, .i_phase_step, .i_code_set, .i_coef_index, .i_coef_re,
        .i_coef_im, .i_out_valid(o_valid), .i_out_stall(i_stall), .i_symbol_re(o_symbol_re),
        .i_symbol_im(o_symbol_im), .i_last_of_frame(o_last_of_frame),
        .o_errors(n_errors), .o_pending(n_pending)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_dsss_multi_frame_despreader_core NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // output side: random stalls, one long hold on request
    initial begin
        int r;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (1500) @(posedge i_clk);
                hold_req = 0;
            end else if (calm) begin
                i_stall <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    i_stall <= 1'b1;
                    repeat ($urandom_range(10, 40)) @(posedge i_clk);
                end else begin
                    i_stall <= (r < 30);
                end
            end
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic put_word(input logic func, input logic signed [15:0] sre, sim,
                            input logic fs, input logic [15:0] ph,
                            input logic signed [15:0] stp, input logic [1:0] cs,
                            input logic [11:0] ci, input logic signed [15:0] cre, cim);
        int g;
        i_func <= func;
        i_sample_re <= sre;
        i_sample_im <= sim;
        i_frame_start <= fs;
        i_start_phase <= ph;
        i_phase_step <= stp;
        i_code_set <= cs;
        i_coef_index <= ci;
        i_coef_re <= cre;
        i_coef_im <= cim;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        n_words++;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic put_sample(input logic signed [15:0] sre, sim, input logic fs,
                              input logic [15:0] ph, input logic signed [15:0] stp,
                              input logic [1:0] cs);
        put_word(1'b0, sre, sim, fs, ph, stp, cs, 12'($urandom), 16'($urandom),
                 16'($urandom));
    endtask

    task automatic put_coef(input logic [1:0] cs, input logic [11:0] ci,
                            input logic signed [15:0] cre, cim);
        put_word(1'b1, 16'($urandom), 16'($urandom), 1'($urandom), 16'($urandom),
                 16'($urandom), cs, ci, cre, cim);
    endtask

    task automatic rand_sample(input int start_pct);
        logic signed [15:0] re, im;
        re = 16'($urandom);
        im = 16'($urandom);
        if ($urandom_range(0, 19) == 0) re = 16'sh8000;
        if ($urandom_range(0, 19) == 0) im = 16'sh7fff;
        put_sample(re, im, $urandom_range(0, 99) < start_pct, 16'($urandom),
                   16'($urandom), 2'($urandom));
    endtask

    task automatic set_mode(input int span, input int pay, input bit rot);
        i_cfg_we <= 1'b1;
        i_cfg_index <= dmfd_pkg::REG_SYMBOL_SPAN;
        i_cfg_data <= dmfd_pkg::CFG_DATA_W'(span);
        @(posedge i_clk);
        i_cfg_index <= dmfd_pkg::REG_PAYLOAD_SYMBOLS;
        i_cfg_data <= dmfd_pkg::CFG_DATA_W'(pay);
        @(posedge i_clk);
        i_cfg_index <= dmfd_pkg::REG_ROTATE_EACH_SYMBOL;
        i_cfg_data <= dmfd_pkg::CFG_DATA_W'(rot);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait until the block is idle and every predicted word has been seen
    task automatic settle();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (n_pending != 0 || o_stall || o_valid) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic run_frames(input int n, input int start_pct);
        put_sample(16'($urandom), 16'($urandom), 1'b1, 16'($urandom), 16'($urandom),
                   2'($urandom));
        repeat (n - 1) rand_sample(start_pct);
        settle();
    endtask

    initial begin
        int span, pay;
        bit rot;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_func = 1'b0;
        i_sample_re = '0;
        i_sample_im = '0;
        i_frame_start = 1'b0;
        i_start_phase = '0;
        i_phase_step = '0;
        i_code_set = '0;
        i_coef_index = '0;
        i_coef_re = '0;
        i_coef_im = '0;
        calm = 0;
        hold_req = 0;
        n_words = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every coefficient position that any setting below can read
        calm = 1;
        for (int s = 0; s < 4; s++) begin
            put_coef(2'(s), 12'd0, 16'sh7fff, 16'sh8000);
            put_coef(2'(s), 12'd1, 16'sh8000, 16'sh7fff);
            for (int k = 2; k < 16; k++)
                put_coef(2'(s), 12'(k), 16'($urandom), 16'($urandom));
        end
        calm = 0;
        put_coef(2'd3, 12'hfff, 16'($urandom), 16'($urandom));
        put_coef(2'd2, 12'haaa, 16'($urandom), 16'($urandom));
        put_coef(2'd1, 12'h555, 16'($urandom), 16'($urandom));

        // phase quadrants, step extremes and a start while all slots are busy
        settle();
        set_mode(4, 2, 1);
        put_sample(16'sh7fff, 16'sh8000, 1'b1, 16'h0000, 16'sh7fff, 2'd0);
        put_sample(16'sh8000, 16'sh7fff, 1'b1, 16'hffff, 16'sh8000, 2'd1);
        put_sample(16'sh7fff, 16'sh7fff, 1'b1, 16'h4000, 16'sh0001, 2'd2);
        put_sample(16'sh8000, 16'sh8000, 1'b1, 16'h8000, 16'shffff, 2'd3);
        put_sample(16'sh0000, 16'sh0000, 1'b1, 16'hc001, 16'sh1234, 2'd0);
        repeat (10) rand_sample(0);
        settle();
        set_mode(4, 2, 0);
        put_sample(16'sh7fff, 16'sh7fff, 1'b1, 16'h0000, 16'sh0000, 2'd1);
        put_sample(16'sh8000, 16'sh8000, 1'b0, 16'h0000, 16'sh0000, 2'd0);
        repeat (8) rand_sample(0);
        settle();

        // register extremes
        set_mode(0, 127, 1);
        run_frames(66, 0);
        set_mode(16, 0, 0);
        run_frames(34, 0);

        // output held off while more frames wait at the input
        set_mode(1, 4, 1);
        hold_req = 1;
        repeat (40) put_sample(16'($urandom), 16'($urandom), 1'b1, 16'($urandom),
                               16'($urandom), 2'($urandom));
        settle();

        while (n_words < 460) begin
            rot = $urandom_range(0, 1);
            span = $urandom_range(1, 4);
            pay = $urandom_range(1, 4);
            calm = ($urandom_range(0, 3) == 0);
            set_mode(span, pay, rot);
            repeat ($urandom_range(20, 50)) begin
                if ($urandom_range(0, 99) < 8)
                    put_coef(2'($urandom), 12'($urandom_range(0, 15)), 16'($urandom),
                             16'($urandom));
                else
                    rand_sample(20);
            end
            settle();
        end
        calm = 0;

        repeat (300) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("tb_dsss_multi_frame_despreader_core OK");
        end else begin
            $display("tb_dsss_multi_frame_despreader_core NOT OK");
        end
        $finish;
    end

endmodule
